// ----- hw/rtl/differential_drive_heading_controller_macros.svh -----
// Assertion helpers shared by the heading controller modules.
`ifndef DIFFERENTIAL_DRIVE_HEADING_CONTROLLER_MACROS_SVH
`define DIFFERENTIAL_DRIVE_HEADING_CONTROLLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DDHC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DDHC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ddhc_pkg.sv -----
`default_nettype none

package ddhc_pkg;

    // Fixed-point constants. Speeds are Q2.14, duties Q1.14, angles Q4.12.
    localparam int Q14_ONE    = 16384;
    localparam int DEADBAND   = 819;
    localparam int DUTY_MAX   = 16220;
    localparam int ANG_PI     = 12868;
    localparam int ANG_TWO_PI = 25736;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        CFG_SPEED_FB_GAIN  = 3'd0,
        CFG_SPEED_REF_GAIN = 3'd1,
        CFG_HEAD_ERR_GAIN  = 3'd2,
        CFG_TURN_RATE_GAIN = 3'd3,
        CFG_RATE_SCALE     = 3'd4,
        CFG_HALF_PERIOD    = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] speed_fb_gain;
        logic [15:0] speed_ref_gain;
        logic [15:0] head_err_gain;
        logic [15:0] turn_rate_gain;
        logic [15:0] rate_scale;
        logic [15:0] half_period;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        speed_fb_gain:  16'd4096,
        speed_ref_gain: 16'd4096,
        head_err_gain:  16'd4096,
        turn_rate_gain: 16'd0,
        rate_scale:     16'd256,
        half_period:    16'd328
    };

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RATE,
        ST_TRAP,
        ST_HEAD,
        ST_ANGLE,
        ST_ERR,
        ST_TURN,
        ST_SUM,
        ST_CMD,
        ST_OUT
    } ctrl_state_t;

    // Operand pair for the shared multiplier.
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_RATE,
        MUL_SPEED_REF,
        MUL_TRAP,
        MUL_SPEED_FB,
        MUL_RATE_DAMP,
        MUL_HEAD_ERR
    } mul_sel_t;

    // Accumulator operation on the registered product.
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_SUB,
        ACC_NEG,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        logic     capture;
        mul_sel_t mul_sel;
        logic     load_w;
        logic     load_h;
        logic     load_err;
        acc_op_t  acc_op;
        logic     load_ut;
        logic     load_cmd;
        logic     finish;
    } ddhc_cmd_t;

    typedef struct packed {
        logic out_busy;
    } ddhc_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ddhc_cfg_regs.sv -----
`default_nettype none

module ddhc_cfg_regs import ddhc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wr_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Address decode; writes to unused indexes are dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_SPEED_FB_GAIN:  cfg_next.speed_fb_gain  = cfg_wr_data;
                CFG_SPEED_REF_GAIN: cfg_next.speed_ref_gain = cfg_wr_data;
                CFG_HEAD_ERR_GAIN:  cfg_next.head_err_gain  = cfg_wr_data;
                CFG_TURN_RATE_GAIN: cfg_next.turn_rate_gain = cfg_wr_data;
                CFG_RATE_SCALE:     cfg_next.rate_scale     = cfg_wr_data;
                CFG_HALF_PERIOD:    cfg_next.half_period    = cfg_wr_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ddhc_ctrl.sv -----
`default_nettype none
`include "differential_drive_heading_controller_macros.svh"

module ddhc_ctrl import ddhc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  ddhc_status_t status,
    output ddhc_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // Next-state logic: one fixed pass through the datapath per sample.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_RATE;
            ST_RATE:  state_next = ST_TRAP;
            ST_TRAP:  state_next = ST_HEAD;
            ST_HEAD:  state_next = ST_ANGLE;
            ST_ANGLE: state_next = ST_ERR;
            ST_ERR:   state_next = ST_TURN;
            ST_TURN:  state_next = ST_SUM;
            ST_SUM:   state_next = ST_CMD;
            ST_CMD:   state_next = ST_OUT;
            ST_OUT:   if (!status.out_busy) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Command decode. The multiplier product is registered, so each state
    // consumes the product selected by the state before it.
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_RATE: begin
                cmd.mul_sel = MUL_RATE;
            end
            ST_TRAP: begin
                cmd.load_w  = 1'b1;
                cmd.mul_sel = MUL_SPEED_REF;
            end
            ST_HEAD: begin
                cmd.mul_sel = MUL_TRAP;
                cmd.acc_op  = ACC_LOAD;
            end
            ST_ANGLE: begin
                cmd.load_h  = 1'b1;
                cmd.mul_sel = MUL_SPEED_FB;
            end
            ST_ERR: begin
                cmd.load_err = 1'b1;
                cmd.acc_op   = ACC_SUB;
                cmd.mul_sel  = MUL_RATE_DAMP;
            end
            ST_TURN: begin
                cmd.load_ut = 1'b1;
                cmd.acc_op  = ACC_NEG;
                cmd.mul_sel = MUL_HEAD_ERR;
            end
            ST_SUM: begin
                cmd.acc_op = ACC_ADD;
            end
            ST_CMD: begin
                cmd.load_cmd = 1'b1;
            end
            ST_OUT: begin
                cmd.finish = !status.out_busy;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // Sequencer checks.
    `DDHC_ASSERT_NEXT(a_capture_starts, aclk, aresetn, cmd.capture, state_reg == ST_RATE, "capture did not start the sequence")
    `DDHC_ASSERT_NOW(a_finish_free, aclk, aresetn, cmd.finish, !status.out_busy, "result loaded while output register was full")
    `DDHC_ASSERT_NEXT(a_out_waits, aclk, aresetn, (state_reg == ST_OUT) && status.out_busy, state_reg == ST_OUT, "sequencer left the output step while stalled")

endmodule

`default_nettype wire

// ----- hw/rtl/ddhc_datapath.sv -----
`default_nettype none
`include "differential_drive_heading_controller_macros.svh"

module ddhc_datapath import ddhc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  ddhc_cmd_t          cmd,
    output ddhc_status_t       status,
    input  cfg_t               cfg,
    input  logic signed [15:0] s_left_speed,
    input  logic signed [15:0] s_right_speed,
    input  logic signed [15:0] s_target_speed,
    input  logic        [14:0] s_target_heading,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [14:0] m_left_duty,
    output logic signed [14:0] m_right_duty
);

    localparam logic signed [15:0] SPD_MAX   = 16'(Q14_ONE);
    localparam logic signed [15:0] SPD_MIN   = -16'(Q14_ONE);
    localparam logic signed [24:0] H_TWO_PI  = 25'(ANG_TWO_PI);
    localparam logic signed [17:0] E_PI      = 18'(ANG_PI);
    localparam logic signed [17:0] E_TWO_PI  = 18'(ANG_TWO_PI);
    localparam logic signed [31:0] UA_ONE    = 32'(Q14_ONE);
    localparam logic signed [31:0] UA_DBAND  = 32'(DEADBAND);
    localparam logic signed [21:0] UT_ONE    = 22'(Q14_ONE);
    localparam logic signed [15:0] CMD_ONE   = 16'(Q14_ONE);
    localparam logic signed [16:0] D_MAX     = 17'(DUTY_MAX);

    // Sample registers.
    logic signed [15:0] vl_reg, vr_reg, vref_reg;
    logic        [14:0] tgt_reg;
    logic signed [15:0] vl_clamp, vr_clamp;

    // Working registers.
    logic signed [40:0] prod_reg;
    logic signed [41:0] acc_reg;
    logic signed [23:0] w_reg;
    logic        [15:0] h_reg;
    logic signed [17:0] err_reg;
    logic signed [21:0] ut_raw_reg;
    logic signed [15:0] ua_reg, ut_reg;

    // Persistent state and output register.
    logic        [15:0] heading_reg;
    logic signed [23:0] prev_w_reg;
    logic               m_valid_reg;
    logic signed [14:0] m_left_duty_reg, m_right_duty_reg;

    // Measured speeds are clamped to plus or minus one on capture.
    always_comb begin
        vl_clamp = s_left_speed;
        if (s_left_speed > SPD_MAX) begin
            vl_clamp = SPD_MAX;
        end else if (s_left_speed < SPD_MIN) begin
            vl_clamp = SPD_MIN;
        end
        vr_clamp = s_right_speed;
        if (s_right_speed > SPD_MAX) begin
            vr_clamp = SPD_MAX;
        end else if (s_right_speed < SPD_MIN) begin
            vr_clamp = SPD_MIN;
        end
    end

    // Speed difference and rounded mean speed.
    logic signed [16:0] speed_diff;
    logic signed [16:0] speed_sum;
    logic signed [15:0] vt;
    logic signed [23:0] w_sum;

    assign speed_diff = {vr_reg[15], vr_reg} - {vl_reg[15], vl_reg};
    assign speed_sum  = {vr_reg[15], vr_reg} + {vl_reg[15], vl_reg} + 17'sd1;
    assign vt         = speed_sum[16:1];
    assign w_sum      = w_reg + prev_w_reg;

    // Operand select for the shared multiplier.
    logic signed [16:0] mul_a;
    logic signed [23:0] mul_b;
    logic signed [40:0] prod_next;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_sel)
            MUL_RATE: begin
                mul_a = $signed({1'b0, cfg.rate_scale});
                mul_b = {{7{speed_diff[16]}}, speed_diff};
            end
            MUL_SPEED_REF: begin
                mul_a = $signed({1'b0, cfg.speed_ref_gain});
                mul_b = {{8{vref_reg[15]}}, vref_reg};
            end
            MUL_TRAP: begin
                mul_a = $signed({1'b0, cfg.half_period});
                mul_b = w_sum;
            end
            MUL_SPEED_FB: begin
                mul_a = $signed({1'b0, cfg.speed_fb_gain});
                mul_b = {{8{vt[15]}}, vt};
            end
            MUL_RATE_DAMP: begin
                mul_a = $signed({1'b0, cfg.turn_rate_gain});
                mul_b = w_reg;
            end
            MUL_HEAD_ERR: begin
                mul_a = $signed({1'b0, cfg.head_err_gain});
                mul_b = {{6{err_reg[17]}}, err_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Turn rate: product rounded by 11 bits.
    logic signed [40:0] w_round;
    logic signed [23:0] w_next;

    assign w_round = prod_reg + 41'sd1024;
    assign w_next  = w_round[34:11];

    // Trapezoid heading step, one wrap into the circle, then saturation.
    logic signed [40:0] t_round;
    logic signed [24:0] h_step, h_raw, h_wrap;
    logic        [15:0] h_next;

    assign t_round = prod_reg + 41'sd32768;
    assign h_step  = t_round[40:16];
    assign h_raw   = $signed({9'b0, heading_reg}) + h_step;

    always_comb begin
        if (h_raw > H_TWO_PI) begin
            h_wrap = h_raw - H_TWO_PI;
        end else if (h_raw < 0) begin
            h_wrap = h_raw + H_TWO_PI;
        end else begin
            h_wrap = h_raw;
        end
        if (h_wrap > H_TWO_PI) begin
            h_next = H_TWO_PI[15:0];
        end else if (h_wrap < 0) begin
            h_next = '0;
        end else begin
            h_next = h_wrap[15:0];
        end
    end

    // Heading error along the shortest turn.
    logic signed [17:0] tgt_e, h_e, tgt_sel, err_next;

    assign tgt_e = $signed({3'b0, tgt_reg});
    assign h_e   = $signed({2'b0, h_reg});

    always_comb begin
        if (tgt_e >= h_e + E_PI) begin
            tgt_sel = tgt_e - E_TWO_PI;
        end else if (tgt_e <= h_e - E_PI) begin
            tgt_sel = tgt_e + E_TWO_PI;
        end else begin
            tgt_sel = tgt_e;
        end
        err_next = tgt_sel - h_e;
    end

    // Accumulator for the two command sums.
    logic signed [41:0] prod_x, acc_next;

    assign prod_x = {prod_reg[40], prod_reg};

    always_comb begin
        case (cmd.acc_op)
            ACC_LOAD: acc_next = prod_x;
            ACC_SUB:  acc_next = acc_reg - prod_x;
            ACC_NEG:  acc_next = -prod_x;
            ACC_ADD:  acc_next = acc_reg + prod_x;
            default:  acc_next = acc_reg;
        endcase
    end

    // Forward command rounded by 12 bits, turn command by 10 bits.
    logic signed [41:0] ut_round, ua_round;
    logic signed [21:0] ut_raw_next;
    logic signed [31:0] ua_raw;
    logic signed [15:0] ua_next, ut_next;

    assign ut_round    = acc_reg + 42'sd2048;
    assign ut_raw_next = ut_round[33:12];
    assign ua_round    = acc_reg + 42'sd512;
    assign ua_raw      = ua_round[41:10];

    // Turn command saturation and deadband; forward command saturation.
    always_comb begin
        if (ua_raw > UA_ONE) begin
            ua_next = CMD_ONE;
        end else if (ua_raw < -UA_ONE) begin
            ua_next = -CMD_ONE;
        end else if ((ua_raw <= UA_DBAND) && (ua_raw >= -UA_DBAND)) begin
            ua_next = '0;
        end else begin
            ua_next = ua_raw[15:0];
        end
        if (ut_raw_reg > UT_ONE) begin
            ut_next = CMD_ONE;
        end else if (ut_raw_reg < -UT_ONE) begin
            ut_next = -CMD_ONE;
        end else begin
            ut_next = ut_raw_reg[15:0];
        end
    end

    // Forward command limited by the turn command, then wheel mixing.
    logic signed [15:0] ua_mag, ut_lim_max, ut_lim;
    logic signed [16:0] dr_sum, dl_sum;
    logic signed [14:0] dr_next, dl_next;

    assign ua_mag     = (ua_reg < 0) ? -ua_reg : ua_reg;
    assign ut_lim_max = CMD_ONE - ua_mag;

    always_comb begin
        if (ut_reg > ut_lim_max) begin
            ut_lim = ut_lim_max;
        end else if (ut_reg < -ut_lim_max) begin
            ut_lim = -ut_lim_max;
        end else begin
            ut_lim = ut_reg;
        end
        dr_sum = {ut_lim[15], ut_lim} + {ua_reg[15], ua_reg};
        dl_sum = {ut_lim[15], ut_lim} - {ua_reg[15], ua_reg};
        if (dr_sum > D_MAX) begin
            dr_next = D_MAX[14:0];
        end else if (dr_sum < -D_MAX) begin
            dr_next = 15'(-D_MAX);
        end else begin
            dr_next = dr_sum[14:0];
        end
        if (dl_sum > D_MAX) begin
            dl_next = D_MAX[14:0];
        end else if (dl_sum < -D_MAX) begin
            dl_next = 15'(-D_MAX);
        end else begin
            dl_next = dl_sum[14:0];
        end
    end

    // Payload registers, loaded under sequencer control.
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (cmd.capture) begin
            vl_reg   <= vl_clamp;
            vr_reg   <= vr_clamp;
            vref_reg <= s_target_speed;
            tgt_reg  <= s_target_heading;
        end
        if (cmd.load_w) begin
            w_reg <= w_next;
        end
        if (cmd.load_h) begin
            h_reg <= h_next;
        end
        if (cmd.load_err) begin
            err_reg <= err_next;
        end
        if (cmd.load_ut) begin
            ut_raw_reg <= ut_raw_next;
        end
        if (cmd.load_cmd) begin
            ua_reg <= ua_next;
            ut_reg <= ut_next;
        end
        if (cmd.finish) begin
            m_left_duty_reg  <= dl_next;
            m_right_duty_reg <= dr_next;
        end
    end

    // Controller state and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heading_reg <= '0;
            prev_w_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.finish) begin
                heading_reg <= h_reg;
                prev_w_reg  <= w_reg;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_busy = m_valid_reg & ~m_ready;
    assign m_valid         = m_valid_reg;
    assign m_left_duty     = m_left_duty_reg;
    assign m_right_duty    = m_right_duty_reg;

    // Datapath checks.
    `DDHC_ASSERT_NOW(a_heading_range, aclk, aresetn, 1'b1, heading_reg <= 16'(ANG_TWO_PI), "heading left the circle")
    `DDHC_ASSERT_NOW(a_duty_range, aclk, aresetn, m_valid_reg, (m_left_duty_reg <= DUTY_MAX) && (m_left_duty_reg >= -DUTY_MAX) && (m_right_duty_reg <= DUTY_MAX) && (m_right_duty_reg >= -DUTY_MAX), "duty beyond saturation limit")
    `DDHC_ASSERT_NEXT(a_result_loads, aclk, aresetn, cmd.finish, m_valid_reg && (heading_reg == $past(h_reg)), "finished sample not presented")

endmodule

`default_nettype wire

// ----- hw/rtl/differential_drive_heading_controller.sv -----
`default_nettype none
// Channel   Handshake            Payload
// s_*       s_valid / s_ready    left_speed, right_speed, target_speed, target_heading
// m_*       m_valid / m_ready    left_duty, right_duty
// cfg_*     cfg_wr_en            cfg_addr (register index), cfg_wr_data
//
// A sample takes a transfer step in idle, then nine sequencer steps that
// share one 17 x 24 bit multiplier across six products.
// Input is taken only between samples; a finished result waits in the output
// register while the next sample is accepted and worked on.
// The last step holds while the output register is full and not taken.
// Reset is synchronous, active low: config and control registers return to their
// reset values, heading and previous turn rate to zero; no clearing pass is needed.

module differential_drive_heading_controller import ddhc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_left_speed,
    input  logic signed [15:0] s_right_speed,
    input  logic signed [15:0] s_target_speed,
    input  logic        [14:0] s_target_heading,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [14:0] m_left_duty,
    output logic signed [14:0] m_right_duty,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_addr,
    input  logic [15:0]        cfg_wr_data
);

    cfg_t         cfg;
    ddhc_cmd_t    cmd;
    ddhc_status_t status;

    // Configuration registers.
    ddhc_cfg_regs u_cfg_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // Sequencer.
    ddhc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Arithmetic, state and output register.
    ddhc_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .cfg              (cfg),
        .s_left_speed     (s_left_speed),
        .s_right_speed    (s_right_speed),
        .s_target_speed   (s_target_speed),
        .s_target_heading (s_target_heading),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_left_duty      (m_left_duty),
        .m_right_duty     (m_right_duty)
    );

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`default_nettype none

module tb_top;
    import ddhc_pkg::*;

    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int LONG_HOLD       = 400;
    localparam int LONG_HOLD_AT    = 700;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic signed [15:0] target_speed;
        logic        [14:0] target_heading;
    } sample_t;

    typedef struct packed {
        logic signed [14:0] left;
        logic signed [14:0] right;
    } duty_t;

    // One directed row: the sample, and the duties where they are known by hand.
    typedef struct packed {
        sample_t smp;
        logic    typed;
        duty_t   want;
    } row_t;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_MOSTLY
    } ready_mode_t;

    localparam int DIRECTED_ROWS = 18;

    // Rows up to the forward-limit row keep the heading at zero, so their
    // duties follow directly from the reset gains.
    localparam row_t DIRECTED [DIRECTED_ROWS] = '{
        '{'{16'sd0, 16'sd0, 16'sd0, 15'd0}, 1'b1, '{15'sd0, 15'sd0}},
        '{'{16'sd0, 16'sd0, 16'sd16384, 15'd0}, 1'b1, '{15'sd16220, 15'sd16220}},
        '{'{16'sd0, 16'sd0, -16'sd16384, 15'd0}, 1'b1, '{-15'sd16220, -15'sd16220}},
        '{'{16'sd0, 16'sd0, 16'sd0, 15'd12868}, 1'b1, '{15'sd16220, -15'sd16220}},
        '{'{16'sd0, 16'sd0, 16'sd0, 15'd12867}, 1'b1, '{-15'sd16220, 15'sd16220}},
        '{'{16'sd0, 16'sd0, 16'sd0, 15'd204}, 1'b1, '{15'sd0, 15'sd0}},
        '{'{16'sd0, 16'sd0, 16'sd0, 15'd205}, 1'b1, '{-15'sd820, 15'sd820}},
        '{'{16'sd0, 16'sd0, 16'sd0, 15'd32767}, 1'b1, '{-15'sd16220, 15'sd16220}},
        '{'{16'sd0, 16'sd0, 16'sd0, 15'd25736}, 1'b1, '{15'sd0, 15'sd0}},
        '{'{16'sd0, 16'sd0, 16'sd16384, 15'd205}, 1'b1, '{15'sd14744, 15'sd16220}},
        '{'{16'sd32767, -16'sd32768, 16'sd0, 15'd0}, 1'b0, '0},
        '{'{-16'sd32768, 16'sd32767, 16'sd16384, 15'd25736}, 1'b0, '0},
        '{'{16'sd16384, 16'sd16384, -16'sd16384, 15'd100}, 1'b0, '0},
        '{'{-16'sd16385, 16'sd16385, 16'sd0, 15'd12868}, 1'b0, '0},
        '{'{16'sd21845, -16'sd21846, 16'sd10922, 15'd10922}, 1'b0, '0},
        '{'{-16'sd1, 16'sd1, -16'sd1, 15'd1}, 1'b0, '0},
        '{'{16'sd1, -16'sd1, 16'sd1, 15'd21845}, 1'b0, '0},
        '{'{16'sd8000, -16'sd8000, 16'sd0, 15'd20000}, 1'b0, '0}
    };

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] in_left = '0;
    logic signed [15:0] in_right = '0;
    logic signed [15:0] in_target_speed = '0;
    logic        [14:0] in_target_heading = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [14:0] out_left;
    logic signed [14:0] out_right;
    logic               cfg_wr_en = 1'b0;
    logic [2:0]         cfg_addr = '0;
    logic [15:0]        cfg_wr_data = '0;

    // Controller model state and register copy.
    cfg_t   model_cfg = CFG_RESET;
    longint model_heading = 0;
    longint model_rate = 0;

    duty_t  expected_duties [$];
    int     duties_checked = 0;
    int     duty_errors = 0;
    int     cycles = 0;

    differential_drive_heading_controller u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_left_speed     (in_left),
        .s_right_speed    (in_right),
        .s_target_speed   (in_target_speed),
        .s_target_heading (in_target_heading),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_left_duty      (out_left),
        .m_right_duty     (out_right),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wr_data      (cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Round to nearest, ties toward plus infinity.
    function automatic longint round_shift(input longint x, input int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint limit(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void apply_reg_write(input logic [2:0] idx, input logic [15:0] data);
        case (idx)
            CFG_SPEED_FB_GAIN:  model_cfg.speed_fb_gain = data;
            CFG_SPEED_REF_GAIN: model_cfg.speed_ref_gain = data;
            CFG_HEAD_ERR_GAIN:  model_cfg.head_err_gain = data;
            CFG_TURN_RATE_GAIN: model_cfg.turn_rate_gain = data;
            CFG_RATE_SCALE:     model_cfg.rate_scale = data;
            CFG_HALF_PERIOD:    model_cfg.half_period = data;
            default: ;
        endcase
    endfunction

    // Computes the wheel duties of one sample and advances heading and turn rate.
    function automatic duty_t predict_duties(input sample_t smp);
        longint vl;
        longint vr;
        longint w;
        longint vt;
        longint h;
        longint tgt;
        longint err;
        longint ut;
        longint ua;
        longint ua_mag;
        longint ut_mag;
        logic   ut_neg;
        longint dl;
        longint dr;
        duty_t  d;
        vl = limit(longint'(smp.left), -Q14_ONE, Q14_ONE);
        vr = limit(longint'(smp.right), -Q14_ONE, Q14_ONE);
        w  = round_shift((vr - vl) * longint'(model_cfg.rate_scale), 11);
        vt = round_shift(vr + vl, 1);

        // Trapezoid step, one wrap, then saturation into a full turn.
        h = model_heading
            + round_shift(longint'(model_cfg.half_period) * (w + model_rate), 16);
        if (h > ANG_TWO_PI) begin
            h = h - ANG_TWO_PI;
        end else if (h < 0) begin
            h = h + ANG_TWO_PI;
        end
        h = limit(h, 0, ANG_TWO_PI);

        // Shortest turn toward the target.
        tgt = longint'(smp.target_heading);
        if (tgt >= ANG_PI + h) begin
            tgt = tgt - ANG_TWO_PI;
        end else if (tgt <= h - ANG_PI) begin
            tgt = tgt + ANG_TWO_PI;
        end
        err = tgt - h;

        ut = round_shift(longint'(model_cfg.speed_ref_gain) * longint'(smp.target_speed)
                         - longint'(model_cfg.speed_fb_gain) * vt, 12);
        ua = round_shift(longint'(model_cfg.head_err_gain) * err * 4
                         - longint'(model_cfg.turn_rate_gain) * w * 4, 12);

        // Turn command: saturation and deadband.
        if (ua > Q14_ONE) begin
            ua = Q14_ONE;
        end else if (ua < -Q14_ONE) begin
            ua = -Q14_ONE;
        end else if (ua <= DEADBAND && ua >= -DEADBAND) begin
            ua = 0;
        end
        ua_mag = (ua < 0) ? -ua : ua;

        // Forward command shares the remaining headroom.
        ut_neg = (ut < 0);
        ut_mag = ut_neg ? -ut : ut;
        if (ut_mag > Q14_ONE) begin
            ut_mag = Q14_ONE;
        end
        if (ut_mag > Q14_ONE - ua_mag) begin
            ut_mag = Q14_ONE - ua_mag;
        end
        ut = ut_neg ? -ut_mag : ut_mag;

        dr = limit(ut + ua, -DUTY_MAX, DUTY_MAX);
        dl = limit(ut - ua, -DUTY_MAX, DUTY_MAX);
        model_heading = h;
        model_rate = w;
        d.left = dl[14:0];
        d.right = dr[14:0];
        return d;
    endfunction

    function automatic logic signed [15:0] random_speed();
        if ($urandom_range(0, 9) == 0) begin
            return 16'($urandom_range(0, 65535));
        end
        return 16'($signed($urandom_range(0, 2 * Q14_ONE)) - Q14_ONE);
    endfunction

    // Mostly in-range samples; some targets sit right at the half-turn boundary.
    function automatic sample_t random_sample();
        sample_t smp;
        int      t;
        smp.left = random_speed();
        smp.right = random_speed();
        smp.target_speed = 16'($signed($urandom_range(0, 2 * Q14_ONE)) - Q14_ONE);
        case ($urandom_range(0, 9))
            0: begin
                t = int'(model_heading) + ANG_PI - 2 + $urandom_range(0, 4);
                if (t > 32767) begin
                    t = t - ANG_TWO_PI;
                end
            end
            1: begin
                t = int'(model_heading) - ANG_PI - 2 + $urandom_range(0, 4);
                if (t < 0) begin
                    t = t + ANG_TWO_PI;
                end
            end
            2: t = $urandom_range(0, 32767);
            default: t = $urandom_range(0, ANG_TWO_PI);
        endcase
        smp.target_heading = 15'(t);
        return smp;
    endfunction

    function automatic cfg_t random_settings(input logic full_range);
        cfg_t c;
        if (full_range) begin
            c = {$urandom, $urandom, $urandom};
        end else begin
            c.speed_fb_gain  = 16'($urandom_range(0, 16384));
            c.speed_ref_gain = 16'($urandom_range(0, 16384));
            c.head_err_gain  = 16'($urandom_range(0, 16384));
            c.turn_rate_gain = 16'($urandom_range(0, 8192));
            c.rate_scale     = 16'($urandom_range(0, 4096));
            c.half_period    = 16'($urandom_range(0, 4096));
        end
        return c;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        apply_reg_write(idx, data);
    endtask

    task automatic load_settings(input cfg_t c);
        write_reg(CFG_SPEED_FB_GAIN, c.speed_fb_gain);
        write_reg(CFG_SPEED_REF_GAIN, c.speed_ref_gain);
        write_reg(CFG_HEAD_ERR_GAIN, c.head_err_gain);
        write_reg(CFG_TURN_RATE_GAIN, c.turn_rate_gain);
        write_reg(CFG_RATE_SCALE, c.rate_scale);
        write_reg(CFG_HALF_PERIOD, c.half_period);
        cfg_wr_en <= 1'b0;
    endtask

    // Holds the sample until its transfer, then queues its expected duties.
    task automatic offer_sample(input sample_t smp, input logic typed, input duty_t want);
        duty_t predicted;
        s_valid <= 1'b1;
        in_left <= smp.left;
        in_right <= smp.right;
        in_target_speed <= smp.target_speed;
        in_target_heading <= smp.target_heading;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_duties(smp);
        expected_duties.push_back(typed ? want : predicted);
    endtask

    task automatic idle_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_duties.size() != 0);
    endtask

    task automatic send_batch(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < count; k++) begin
                offer_sample(random_sample(), 1'b0, '0);
                sent++;
            end
            idle_gap();
        end
    endtask

    // Stimulus: directed rows, then phases of random samples under new settings.
    initial begin
        cfg_t phase_cfg;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i]) begin
            offer_sample(DIRECTED[i].smp, DIRECTED[i].typed, DIRECTED[i].want);
            if ($urandom_range(0, 2) == 0) begin
                idle_gap();
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p)
                0: begin
                    // Indexes past the last register must leave everything as it was.
                    for (int i = CFG_HALF_PERIOD + 1; i < (1 << $bits(cfg_addr)); i++) begin
                        write_reg(3'(i), 16'($urandom));
                    end
                    phase_cfg = random_settings(1'b0);
                end
                1: phase_cfg = '0;
                2: phase_cfg = '1;
                3: phase_cfg = random_settings(1'b0);
                4: begin
                    phase_cfg = random_settings(1'b0);
                    phase_cfg.rate_scale = 16'($urandom_range(16384, 65535));
                    phase_cfg.half_period = 16'($urandom_range(8192, 65535));
                end
                5: phase_cfg = random_settings(1'b1);
                default: phase_cfg = CFG_RESET;
            endcase
            load_settings(phase_cfg);
            send_batch(ITEMS_PER_PHASE);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (duty_errors == 0 && expected_duties.size() == 0) begin
            $display("differential_drive_heading_controller: match");
        end else begin
            $display("differential_drive_heading_controller: mismatch");
        end
        $finish;
    end

    // Result side back-pressure: changing patterns, and one long hold-off.
    ready_mode_t ready_mode = RDY_ALWAYS;
    int          pattern_left = 0;
    int          hold_left = 0;
    logic        long_hold_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!long_hold_done && duties_checked >= LONG_HOLD_AT) begin
            m_ready <= 1'b0;
            hold_left <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end else begin
            if (pattern_left == 0) begin
                ready_mode <= ready_mode_t'($urandom_range(0, 3));
                pattern_left <= $urandom_range(8, 80);
            end else begin
                pattern_left <= pattern_left - 1;
            end
            case (ready_mode)
                RDY_ALWAYS: m_ready <= 1'b1;
                RDY_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RDY_SPARSE: m_ready <= (pattern_left % 4 == 0);
                default:    m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Compare every result transfer with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_duties.size() == 0) begin
                duty_errors <= duty_errors + 1;
                if (duty_errors < REPORT_LIMIT) begin
                    $display("unexpected duty transfer %0d: got %0d/%0d",
                             duties_checked, out_left, out_right);
                end
            end else begin
                if (out_left !== expected_duties[0].left
                    || out_right !== expected_duties[0].right) begin
                    duty_errors <= duty_errors + 1;
                    if (duty_errors < REPORT_LIMIT) begin
                        $display("duty error at result %0d: expected %0d/%0d, got %0d/%0d",
                                 duties_checked, expected_duties[0].left,
                                 expected_duties[0].right, out_left, out_right);
                    end
                end
                void'(expected_duties.pop_front());
            end
            duties_checked <= duties_checked + 1;
        end
    end

    // Run time limit.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("differential_drive_heading_controller: mismatch");
            $finish;
        end
    end

endmodule

`default_nettype wire
